>>> rtl/tbst_pkg.sv
// Shared types, widths and register codes for the two-beam speed trap.
package tbst_pkg;

    localparam int SAMPLE_BITS       = 10;
    localparam int ELAPSED_BITS_DEF  = 24;
    localparam int THR_W             = SAMPLE_BITS;
    localparam int LIMIT_W           = 10;
    localparam int NUM_W             = 20;
    localparam int TICK_W            = 10;
    localparam int SPEED_W           = 16;
    localparam int CFG_DATA_W        = 20;
    localparam int CFG_IDX_W         = 4;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(400);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(80);
    localparam logic [NUM_W-1:0]   NUM_RESET   = NUM_W'(3600);
    localparam logic [TICK_W-1:0]  TICK_RESET  = TICK_W'(100);
    localparam logic [SPEED_W-1:0] SPEED_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DARK_THRESHOLD  = 4'd0,
        CFG_SPEED_LIMIT     = 4'd1,
        CFG_SPEED_NUMERATOR = 4'd2,
        CFG_TICK_MS         = 4'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sensor_a;
        logic [SAMPLE_BITS-1:0] sensor_b;
        logic                   button_edge;
        logic                   tick;
    } t_in_item;

    typedef struct packed {
        logic               power_lamp;
        logic               timing_lamp;
        logic               measurement_valid;
        logic [SPEED_W-1:0] speed_kmh;
        logic               violation;
    } t_out_item;

    typedef struct packed {
        logic power;
        logic timing;
        logic valid;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

>>> rtl/two_beam_speed_trap.sv
// Top level of the two-beam speed trap: configuration registers, front end, queue, back end.
//
// Input requests are pushed with i_push while o_full is low; each carries both sensor
// readings, a power button edge and a time tick. Every request gives exactly one result,
// shown on o_result while o_empty is low and taken with i_pop.
// A result holds the power and timing lamps after the request and, when the request ended
// a passage, the speed in whole km/h and the violation flag.
// The front end takes one request per cycle, while the queue is not full, into a four-entry
// job queue. The back end takes a request that ends no passage, or ends one with zero
// elapsed time, straight to its result; one that ends a timed passage first goes through
// the 20-step serial divider that forms the speed.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while the block is
// idle; unknown indexes are ignored.
// Synchronous reset restores the register defaults, switches power on, stops timing and
// empties the queue and the result register.
// When the receiver stalls the result register holds, the back end waits, the queue fills
// and o_full then holds off new requests.
module two_beam_speed_trap
    import tbst_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_in_item              i_item,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int JOB_W = FLAGS_W + ELAPSED_BITS;

    logic [THR_W-1:0]        r_dark_threshold;
    logic [LIMIT_W-1:0]      r_speed_limit;
    logic [NUM_W-1:0]        r_speed_numerator;
    logic [TICK_W-1:0]       r_tick_ms;

    logic                    w_q_push;
    logic                    w_q_full;
    logic                    w_q_pop;
    logic                    w_q_empty;
    t_flags                  w_flags;
    logic [ELAPSED_BITS-1:0] w_elapsed;
    logic [JOB_W-1:0]        w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark_threshold  <= THR_RESET;
            r_speed_limit     <= LIMIT_RESET;
            r_speed_numerator <= NUM_RESET;
            r_tick_ms         <= TICK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DARK_THRESHOLD:  r_dark_threshold  <= i_cfg_data[THR_W-1:0];
                CFG_SPEED_LIMIT:     r_speed_limit     <= i_cfg_data[LIMIT_W-1:0];
                CFG_SPEED_NUMERATOR: r_speed_numerator <= i_cfg_data[NUM_W-1:0];
                CFG_TICK_MS:         r_tick_ms         <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_full = w_q_full;

    tbst_front #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_item          (i_item),
        .i_dark_threshold(r_dark_threshold),
        .i_tick_ms       (r_tick_ms),
        .i_q_full        (w_q_full),
        .o_q_push        (w_q_push),
        .o_flags         (w_flags),
        .o_elapsed       (w_elapsed)
    );

    tbst_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_data ({w_flags, w_elapsed}),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_data (w_q_out),
        .o_empty(w_q_empty)
    );

    tbst_back #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .i_q_data         (w_q_out),
        .o_q_pop          (w_q_pop),
        .i_speed_limit    (r_speed_limit),
        .i_speed_numerator(r_speed_numerator),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_result         (o_result)
    );

endmodule

>>> rtl/tbst_front.sv
// Front end: accepts requests, updates power and timing state, and queues one job per request.
module tbst_front
    import tbst_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  t_in_item                i_item,
    input  logic [THR_W-1:0]        i_dark_threshold,
    input  logic [TICK_W-1:0]       i_tick_ms,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output t_flags                  o_flags,
    output logic [ELAPSED_BITS-1:0] o_elapsed
);

    logic                    r_powered;
    logic                    r_timing;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic                    n_powered;
    logic                    n_timing;
    logic [ELAPSED_BITS-1:0] n_elapsed;
    logic [ELAPSED_BITS:0]   w_sum;
    logic                    w_start;
    logic                    w_stop;
    logic                    w_timing_mid;
    logic [ELAPSED_BITS-1:0] w_elapsed_tick;

    assign o_q_push = i_push && !i_q_full;
    assign w_sum    = {1'b0, r_elapsed} + (ELAPSED_BITS + 1)'(i_tick_ms);

    always_comb begin
        n_powered      = r_powered ^ i_item.button_edge;
        w_elapsed_tick = r_elapsed;
        if (i_item.tick && r_timing) begin
            w_elapsed_tick = w_sum[ELAPSED_BITS] ? '1 : w_sum[ELAPSED_BITS-1:0];
        end
        w_start      = n_powered && !r_timing && (i_item.sensor_a < i_dark_threshold);
        w_timing_mid = r_timing || w_start;
        n_elapsed    = w_start ? '0 : w_elapsed_tick;
        w_stop       = n_powered && w_timing_mid && (i_item.sensor_b < i_dark_threshold);
        n_timing     = w_timing_mid && !w_stop;
    end

    assign o_flags.power  = n_powered;
    assign o_flags.timing = n_timing;
    assign o_flags.valid  = w_stop;
    assign o_elapsed      = n_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_powered <= 1'b1;
            r_timing  <= 1'b0;
            r_elapsed <= '0;
        end else if (o_q_push) begin
            r_powered <= n_powered;
            r_timing  <= n_timing;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

>>> rtl/tbst_queue.sv
// Small job queue between the front end and the divider back end.
module tbst_queue
    import tbst_pkg::*;
#(
    parameter int WIDTH = FLAGS_W + ELAPSED_BITS_DEF,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tbst_back.sv
// Back end: serial speed divider, violation compare and the result register.
module tbst_back
    import tbst_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  logic [FLAGS_W+ELAPSED_BITS-1:0]   i_q_data,
    output logic                              o_q_pop,
    input  logic [LIMIT_W-1:0]                i_speed_limit,
    input  logic [NUM_W-1:0]                  i_speed_numerator,
    input  logic                              i_pop,
    output logic                              o_empty,
    output t_out_item                         o_result
);

    localparam int PROD_W = LIMIT_W + ELAPSED_BITS;
    localparam int CNT_W  = $clog2(NUM_W);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} t_state;

    t_state                  r_state;
    t_flags                  r_flags;
    logic [ELAPSED_BITS-1:0] r_den;
    logic [ELAPSED_BITS-1:0] r_rem;
    logic [NUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_cnt;
    logic [PROD_W-1:0]       r_prod;
    t_out_item               r_out;
    logic                    r_out_valid;

    t_flags                  w_job_flags;
    logic [ELAPSED_BITS-1:0] w_job_elapsed;
    logic [ELAPSED_BITS:0]   w_trial;
    logic                    w_fits;
    logic [SPEED_W-1:0]      w_speed;
    logic                    w_viol;

    assign w_job_flags   = t_flags'(i_q_data[FLAGS_W+ELAPSED_BITS-1:ELAPSED_BITS]);
    assign w_job_elapsed = i_q_data[ELAPSED_BITS-1:0];
    assign o_q_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty       = !r_out_valid;
    assign o_result      = r_out;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_comb begin
        w_speed = '0;
        w_viol  = 1'b0;
        if (r_flags.valid) begin
            if (r_den == '0) begin
                w_speed = SPEED_MAX;
            end else if (r_quo[NUM_W-1:SPEED_W] != '0) begin
                w_speed = SPEED_MAX;
            end else begin
                w_speed = r_quo[SPEED_W-1:0];
            end
            w_viol = PROD_W'(i_speed_numerator) > r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && (!r_out_valid || i_pop)) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_flags <= w_job_flags;
                        r_den   <= w_job_elapsed;
                        r_rem   <= '0;
                        r_quo   <= i_speed_numerator;
                        r_cnt   <= CNT_W'(NUM_W - 1);
                        r_prod  <= PROD_W'(i_speed_limit) * PROD_W'(w_job_elapsed);
                        if (w_job_flags.valid && (w_job_elapsed != '0)) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_fits ? ELAPSED_BITS'(w_trial - {1'b0, r_den})
                                    : w_trial[ELAPSED_BITS-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], w_fits};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_pop) begin
                        r_out.power_lamp        <= r_flags.power;
                        r_out.timing_lamp       <= r_flags.timing;
                        r_out.measurement_valid <= r_flags.valid;
                        r_out.speed_kmh         <= w_speed;
                        r_out.violation         <= w_viol;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid)
        else $error("Result was dropped without being taken.");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_den != '0)
        else $error("Divider started with a zero divisor.");

    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.measurement_valid |->
            r_out.speed_kmh == '0 && !r_out.violation)
        else $error("Result without a measurement carries a speed or violation.");

    a_meas_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.measurement_valid |-> !r_out.timing_lamp)
        else $error("A finished measurement still shows timing.");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the two-beam speed trap: scoreboard class, drivers and phases.
module tb_top;
    import tbst_pkg::*;

    localparam int ELAPSED_BITS     = ELAPSED_BITS_DEF;
    localparam int IN_W             = $bits(t_in_item);
    localparam int FIRST_UNUSED_IDX = CFG_TICK_MS + 1;
    localparam int LAST_IDX         = (1 << CFG_IDX_W) - 1;
    localparam int SAMPLE_TOP       = (1 << SAMPLE_BITS) - 1;
    localparam int LONG_TICKS       = 120;
    localparam int STALL_LIMIT      = 2000;
    localparam int HOLD_CYCLES      = 200;

    class speed_trap_scoreboard;
        logic [THR_W-1:0]        dark_thr;
        logic [LIMIT_W-1:0]      limit_kmh;
        logic [NUM_W-1:0]        numerator;
        logic [TICK_W-1:0]       tick_len;
        logic                    powered;
        logic                    timing;
        logic [ELAPSED_BITS-1:0] elapsed;
        t_out_item               pending_reports[$];
        int                      errors;
        int                      measurements;
        int                      full_scale;
        int                      violations;
        int                      ceilings;

        function new();
            dark_thr     = THR_RESET;
            limit_kmh    = LIMIT_RESET;
            numerator    = NUM_RESET;
            tick_len     = TICK_RESET;
            powered      = 1'b1;
            timing       = 1'b0;
            elapsed      = '0;
            errors       = 0;
            measurements = 0;
            full_scale   = 0;
            violations   = 0;
            ceilings     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DARK_THRESHOLD:  dark_thr  = data[THR_W-1:0];
                CFG_SPEED_LIMIT:     limit_kmh = data[LIMIT_W-1:0];
                CFG_SPEED_NUMERATOR: numerator = data[NUM_W-1:0];
                CFG_TICK_MS:         tick_len  = data[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(t_in_item req);
            t_out_item       rep;
            longint unsigned total;
            longint unsigned quotient;
            rep = '0;
            if (req.button_edge) begin
                powered = !powered;
            end
            if (req.tick && timing) begin
                total = longint'(elapsed) + longint'(tick_len);
                if (total > longint'({ELAPSED_BITS{1'b1}})) begin
                    elapsed = '1;
                    ceilings++;
                end else begin
                    elapsed = total[ELAPSED_BITS-1:0];
                end
            end
            if (powered) begin
                if (req.sensor_a < dark_thr && !timing) begin
                    timing  = 1'b1;
                    elapsed = '0;
                end
                if (req.sensor_b < dark_thr && timing) begin
                    timing = 1'b0;
                    rep.measurement_valid = 1'b1;
                    if (elapsed == '0) begin
                        rep.speed_kmh = SPEED_MAX;
                    end else begin
                        quotient = longint'(numerator) / longint'(elapsed);
                        rep.speed_kmh = (quotient > longint'(SPEED_MAX)) ?
                                        SPEED_MAX : quotient[SPEED_W-1:0];
                    end
                    rep.violation = longint'(numerator) >
                                    longint'(limit_kmh) * longint'(elapsed);
                    measurements++;
                    if (rep.speed_kmh == SPEED_MAX) full_scale++;
                    if (rep.violation) violations++;
                end
            end
            rep.power_lamp  = powered;
            rep.timing_lamp = timing;
            pending_reports.push_back(rep);
        endfunction

        function void compare_field(string name, longint unsigned want, logic [SPEED_W-1:0] got);
            if (got !== want[SPEED_W-1:0]) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_reports.size() == 0) begin
                $error("result arrived with no request pending: %p", got);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("power_lamp", want.power_lamp, got.power_lamp);
            compare_field("timing_lamp", want.timing_lamp, got.timing_lamp);
            compare_field("measurement_valid", want.measurement_valid, got.measurement_valid);
            compare_field("speed_kmh", want.speed_kmh, got.speed_kmh);
            compare_field("violation", want.violation, got.violation);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_push;
    logic                  o_full;
    t_in_item              i_item;
    logic                  o_empty;
    logic                  i_pop;
    t_out_item             o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    speed_trap_scoreboard sb = new();
    int send_idle_pct = 32;
    int recv_idle_pct = 32;
    int hold_request  = 0;
    int sent          = 0;
    int settings      = 0;

    two_beam_speed_trap dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_item     (i_item),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic bit coin(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic t_in_item req_of(int a, int b, bit btn, bit tck);
        t_in_item req;
        req.sensor_a    = SAMPLE_BITS'(a);
        req.sensor_b    = SAMPLE_BITS'(b);
        req.button_edge = btn;
        req.tick        = tck;
        return req;
    endfunction

    function automatic int dark_level();
        if (sb.dark_thr == '0) return $urandom_range(SAMPLE_TOP);
        return $urandom_range(0, sb.dark_thr - 1);
    endfunction

    function automatic int bright_level();
        return $urandom_range(sb.dark_thr, SAMPLE_TOP);
    endfunction

    task automatic push_request(input t_in_item req);
        while (coin(send_idle_pct)) begin
            i_push <= 1'b0;
            i_item <= IN_W'($urandom);
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (o_full);
        sb.note_request(req);
        sent++;
    endtask

    task automatic wait_drained();
        i_push <= 1'b0;
        do @(posedge i_clk); while (sb.pending_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    function automatic logic [CFG_DATA_W-1:0] narrow_data(int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value) & CFG_DATA_W'(SAMPLE_TOP);
        if (coin(50)) data |= CFG_DATA_W'($urandom) & ~CFG_DATA_W'(SAMPLE_TOP);
        return data;
    endfunction

    task automatic program_regs(input int thr, input int lim, input int num, input int tck);
        wait_drained();
        repeat (3) @(posedge i_clk);
        write_reg(CFG_DARK_THRESHOLD, narrow_data(thr));
        write_reg(CFG_SPEED_LIMIT, narrow_data(lim));
        write_reg(CFG_SPEED_NUMERATOR, CFG_DATA_W'(num));
        write_reg(CFG_TICK_MS, narrow_data(tck));
        write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, LAST_IDX)), CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    task automatic send_passage();
        int span;
        span = $urandom_range(0, 10);
        push_request(req_of(dark_level(), coin(15) ? dark_level() : bright_level(),
                            coin(3), coin(50)));
        repeat (span) begin
            push_request(req_of($urandom_range(SAMPLE_TOP), bright_level(), coin(3), coin(80)));
        end
        push_request(req_of($urandom_range(SAMPLE_TOP), dark_level(), coin(3), coin(50)));
    endtask

    task automatic run_random_phase(input int n_items, input bit mid_pause);
        int first;
        first = sent;
        while (sent - first < n_items) begin
            if (mid_pause && sent - first >= n_items / 2) begin
                wait_drained();
                mid_pause = 1'b0;
            end
            if (coin(20)) begin
                push_request(IN_W'($urandom));
            end else begin
                send_passage();
            end
        end
    endtask

    initial begin
        i_pop <= 1'b0;
        forever begin
            int hold_left;
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) sb.check_result(o_result);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= !coin(recv_idle_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_push && !o_full) || (i_pop && !o_empty) || i_cfg_we || !i_rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog: no request moved for %0d cycles, %0d results outstanding.",
                 STALL_LIMIT, sb.pending_reports.size());
        $display("** two_beam_speed_trap: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_push     <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: zero-time passage, normal passages, power toggled mid-passage.
        push_request(req_of(1023, 1023, 0, 0));
        push_request(req_of(0, 0, 0, 1));
        push_request(req_of(0, 1023, 0, 0));
        push_request(req_of(1023, 1023, 0, 1));
        push_request(req_of(1023, 0, 0, 0));
        push_request(req_of(399, 1023, 0, 0));
        push_request(req_of(400, 400, 0, 1));
        push_request(req_of(1023, 399, 0, 0));
        push_request(req_of(0, 1023, 1, 0));
        push_request(req_of(0, 1023, 1, 0));
        push_request(req_of(1023, 1023, 1, 1));
        push_request(req_of(1023, 0, 0, 1));
        push_request(req_of(1023, 0, 1, 0));
        push_request(req_of(0, 0, 1, 1));
        push_request(req_of(1023, 1023, 1, 0));

        // Largest numerator over one millisecond saturates the speed.
        program_regs(1023, 0, (1 << NUM_W) - 1, 1);
        push_request(req_of(0, 1023, 0, 0));
        push_request(req_of(1022, 1023, 0, 1));
        push_request(req_of(1023, 1022, 0, 0));

        // A zero threshold never sees a dark beam; a zero numerator never violates.
        program_regs(0, 1023, 0, 1023);
        push_request(req_of(0, 0, 0, 1));
        program_regs(1, 1023, 0, 1023);
        push_request(req_of(0, 0, 0, 0));
        push_request(req_of(0, 1023, 0, 0));
        push_request(req_of(1023, 1023, 0, 1));
        push_request(req_of(1023, 0, 0, 0));

        // One long passage with a tick on every request between start and stop, without idling.
        program_regs(512, 1023, (1 << NUM_W) - 1, 1023);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_request(req_of(0, 1023, 0, 0));
        repeat (LONG_TICKS) push_request(req_of($urandom_range(SAMPLE_TOP), bright_level(), 0, 1));
        push_request(req_of(1023, 0, 0, 0));
        send_idle_pct = 32;
        recv_idle_pct = 32;

        program_regs($urandom_range(200, 800), $urandom_range(0, 1023),
                     $urandom_range(1, 1000000), $urandom_range(1, 1000));
        hold_request = HOLD_CYCLES;
        run_random_phase(250, 1'b0);
        program_regs(1, 1023, 1000000, 1000);
        run_random_phase(250, 1'b0);
        program_regs(1023, 0, $urandom_range(1, 5000), $urandom_range(1, 20));
        run_random_phase(250, 1'b1);
        program_regs($urandom_range(1, 1023), $urandom_range(0, 1023),
                     $urandom_range(1, 1000000), $urandom_range(1, 1000));
        run_random_phase(250, 1'b0);

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d requests over %0d register settings, %0d measurements.",
                 sent, settings, sb.measurements);
        $display("Full-scale speeds: %0d, violations: %0d, elapsed ceiling hits: %0d.",
                 sb.full_scale, sb.violations, sb.ceilings);
        if (sb.errors == 0) begin
            $display("** two_beam_speed_trap: PASSED **");
        end else begin
            $display("** two_beam_speed_trap: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/tbst_pkg.sv
rtl/tbst_front.sv
rtl/tbst_queue.sv
rtl/tbst_back.sv
rtl/two_beam_speed_trap.sv
dv/tb_top.sv
